// ===== rtl/rpsa_pkg.sv =====
// Shared types and constants of the ROM patch stream applier.
`default_nettype none

package rpsa_pkg;

  // Default ROM size in bytes.
  localparam int unsigned RomBytesDefault = 524288;

  // Header layout: signature, version, source hash, target hash.
  localparam int unsigned HeaderBytes = 25;
  localparam logic [4:0] SigEndIdx    = 5'd8;
  localparam logic [4:0] VerIdx       = 5'd8;
  localparam logic [4:0] SrcEndIdx    = 5'd17;
  localparam logic [4:0] HdrLastIdx   = 5'(HeaderBytes - 1);

  // Location field: three little-endian bytes.
  localparam logic [1:0] LocLastIdx = 2'd2;

  localparam int unsigned AddrWidth = 19;
  localparam int unsigned PtrWidth  = 24;

  typedef enum logic [2:0] {
    ST_BUSY    = 3'd0,
    ST_DONE    = 3'd1,
    ST_INVALID = 3'd2,
    ST_VERSION = 3'd3,
    ST_SOURCE  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_SIGNATURE   = 2'd0,
    CFG_VERSION     = 2'd1,
    CFG_SOURCE_HASH = 2'd2
  } cfg_reg_e;

  typedef enum logic [5:0] {
    PH_HEADER   = 6'b000001,
    PH_LENGTH   = 6'b000010,
    PH_COUNT    = 6'b000100,
    PH_LOCATION = 6'b001000,
    PH_DATA     = 6'b010000,
    PH_DONE     = 6'b100000
  } phase_e;

  typedef struct packed {
    logic                 write_valid;
    logic [AddrWidth-1:0] write_address;
    logic [7:0]           write_data;
    status_e              status;
    logic [63:0]          target_hash;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/rpsa_if.sv =====
// Stream interfaces for patch bytes in and result items out.
`default_nettype none

interface rpsa_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] patch_byte;
  logic       end_of_file;

  modport source (output valid, output patch_byte, output end_of_file, input ready);
  modport sink (input valid, input patch_byte, input end_of_file, output ready);
endinterface

interface rpsa_out_if;
  logic                          valid;
  logic                          ready;
  logic                          write_valid;
  logic [rpsa_pkg::AddrWidth-1:0] write_address;
  logic [7:0]                    write_data;
  logic [2:0]                    status;
  logic [63:0]                   target_hash;

  modport source (output valid, output write_valid, output write_address,
                  output write_data, output status, output target_hash, input ready);
  modport sink (input valid, input write_valid, input write_address,
                input write_data, input status, input target_hash, output ready);
endinterface

`default_nettype wire

// ===== rtl/rom_patch_stream_applier.sv =====
// Top level of the ROM patch stream applier: parser, checks and result buffering.
`default_nettype none

// The block parses a patch file that arrives one byte per request on patch_i and
// gives exactly one result request on result_o for every byte it accepts. The
// first 25 bytes are the header (8-byte signature, version byte, 8-byte source
// hash, 8-byte target hash, all little-endian); at the last header byte the
// signature, version and source hash are checked against the configuration
// registers in that order. Records follow: a length byte, a count byte and count
// entries of a 3-byte little-endian location followed by length data bytes; each
// data byte comes out as a ROM write to consecutive addresses. Errors are sticky
// until reset, and after an error or after done further bytes only repeat the
// final status. The block sustains one byte per clock cycle while the sink
// keeps up: the whole parse step for a byte is one short combinational update
// of the parser registers, and its result is registered in the output register
// or, while the sink stalls, in the skid register behind it, which keeps input
// flowing for one extra result, so patch_i.ready depends only on the skid register.
// Configuration registers must be written while the block is idle; the ROM size
// ROM_BYTES sets only the address range check.
module rom_patch_stream_applier #(
  parameter int unsigned ROM_BYTES = rpsa_pkg::RomBytesDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  rpsa_in_if.sink          patch_i,
  rpsa_out_if.source       result_o
);

  // Range check is done on a 25-bit sum, wide enough for a 24-bit pointer plus length.
  localparam logic [rpsa_pkg::PtrWidth:0] RomLimit = (rpsa_pkg::PtrWidth + 1)'(ROM_BYTES);

  // Configuration registers.
  logic [63:0] exp_sig_q;
  logic [7:0]  exp_ver_q;
  logic [63:0] src_hash_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_sig_q  <= '0;
      exp_ver_q  <= 8'd1;
      src_hash_q <= '0;
    end else if (cfg_we_i) begin
      case (rpsa_pkg::cfg_reg_e'(cfg_index_i))
        rpsa_pkg::CFG_SIGNATURE:   exp_sig_q  <= cfg_data_i;
        rpsa_pkg::CFG_VERSION:     exp_ver_q  <= cfg_data_i[7:0];
        rpsa_pkg::CFG_SOURCE_HASH: src_hash_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Parser state.
  rpsa_pkg::phase_e               phase_q, phase_d;
  rpsa_pkg::status_e              err_q, err_d;
  logic [4:0]                     hdr_cnt_q, hdr_cnt_d;
  logic [63:0]                    sig_q, sig_d;
  logic [7:0]                     ver_q, ver_d;
  logic [63:0]                    src_q, src_d;
  logic [63:0]                    tgt_q, tgt_d;
  logic [7:0]                     rec_len_q, rec_len_d;
  logic [7:0]                     entries_q, entries_d;
  logic [1:0]                     loc_cnt_q, loc_cnt_d;
  logic [7:0]                     data_left_q, data_left_d;
  logic [rpsa_pkg::PtrWidth-1:0]  wptr_q, wptr_d;

  logic                           in_acc;
  logic [7:0]                     in_byte;
  logic [rpsa_pkg::PtrWidth-1:0]  loc_ptr;
  logic [rpsa_pkg::PtrWidth:0]    loc_end;
  rpsa_pkg::result_t              res;

  assign in_acc  = patch_i.valid && patch_i.ready;
  assign in_byte = patch_i.patch_byte;
  assign loc_ptr = {in_byte, wptr_q[rpsa_pkg::PtrWidth-1:8]};
  assign loc_end = {1'b0, loc_ptr} + (rpsa_pkg::PtrWidth + 1)'(rec_len_q);

  always_comb begin
    phase_d     = phase_q;
    err_d       = err_q;
    hdr_cnt_d   = hdr_cnt_q;
    sig_d       = sig_q;
    ver_d       = ver_q;
    src_d       = src_q;
    tgt_d       = tgt_q;
    rec_len_d   = rec_len_q;
    entries_d   = entries_q;
    loc_cnt_d   = loc_cnt_q;
    data_left_d = data_left_q;
    wptr_d      = wptr_q;
    res         = '0;

    if (in_acc && err_q == rpsa_pkg::ST_BUSY && phase_q != rpsa_pkg::PH_DONE) begin
      case (phase_q)
        rpsa_pkg::PH_HEADER: begin
          if (hdr_cnt_q < rpsa_pkg::SigEndIdx) begin
            sig_d = {in_byte, sig_q[63:8]};
          end else if (hdr_cnt_q == rpsa_pkg::VerIdx) begin
            ver_d = in_byte;
          end else if (hdr_cnt_q < rpsa_pkg::SrcEndIdx) begin
            src_d = {in_byte, src_q[63:8]};
          end else begin
            tgt_d = {in_byte, tgt_q[63:8]};
          end
          hdr_cnt_d = hdr_cnt_q + 5'd1;
          // The last header byte only feeds the target hash, so the checked
          // words are already complete in their registers.
          if (hdr_cnt_q == rpsa_pkg::HdrLastIdx) begin
            if (sig_q != exp_sig_q) begin
              err_d = rpsa_pkg::ST_INVALID;
            end else if (ver_q != exp_ver_q) begin
              err_d = rpsa_pkg::ST_VERSION;
            end else if (src_q != src_hash_q) begin
              err_d = rpsa_pkg::ST_SOURCE;
            end else begin
              phase_d = rpsa_pkg::PH_LENGTH;
            end
          end
        end
        rpsa_pkg::PH_LENGTH: begin
          rec_len_d = in_byte;
          phase_d   = rpsa_pkg::PH_COUNT;
        end
        rpsa_pkg::PH_COUNT: begin
          entries_d = in_byte;
          if (in_byte == 8'd0) begin
            phase_d = rpsa_pkg::PH_LENGTH;
          end else begin
            loc_cnt_d = 2'd0;
            phase_d   = rpsa_pkg::PH_LOCATION;
          end
        end
        rpsa_pkg::PH_LOCATION: begin
          wptr_d    = loc_ptr;
          loc_cnt_d = loc_cnt_q + 2'd1;
          if (loc_cnt_q == rpsa_pkg::LocLastIdx) begin
            loc_cnt_d = 2'd0;
            // A zero length or a record that runs past the end of the ROM is rejected
            // before any of its bytes are written.
            if (rec_len_q == 8'd0 || loc_end > RomLimit) begin
              err_d = rpsa_pkg::ST_INVALID;
            end else begin
              data_left_d = rec_len_q;
              phase_d     = rpsa_pkg::PH_DATA;
            end
          end
        end
        rpsa_pkg::PH_DATA: begin
          if (data_left_q == 8'd0) begin
            err_d = rpsa_pkg::ST_INVALID;
          end else begin
            res.write_valid   = 1'b1;
            res.write_address = wptr_q[rpsa_pkg::AddrWidth-1:0];
            res.write_data    = in_byte;
            wptr_d            = wptr_q + rpsa_pkg::PtrWidth'(1);
            data_left_d       = data_left_q - 8'd1;
            if (data_left_q == 8'd1) begin
              entries_d = entries_q - 8'd1;
              phase_d   = (entries_q == 8'd1) ? rpsa_pkg::PH_LENGTH : rpsa_pkg::PH_LOCATION;
            end
          end
        end
        default: begin
          err_d = rpsa_pkg::ST_INVALID;
        end
      endcase

      // End of file is clean only where a new record would start.
      if (patch_i.end_of_file && err_d == rpsa_pkg::ST_BUSY) begin
        if (phase_d == rpsa_pkg::PH_LENGTH) begin
          phase_d = rpsa_pkg::PH_DONE;
        end else begin
          err_d = rpsa_pkg::ST_INVALID;
        end
      end
    end

    if (err_d != rpsa_pkg::ST_BUSY) begin
      res.status = err_d;
    end else if (phase_d == rpsa_pkg::PH_DONE) begin
      res.status = rpsa_pkg::ST_DONE;
    end else begin
      res.status = rpsa_pkg::ST_BUSY;
    end
    res.target_hash = (res.status == rpsa_pkg::ST_DONE) ? tgt_d : 64'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= rpsa_pkg::PH_HEADER;
      err_q       <= rpsa_pkg::ST_BUSY;
      hdr_cnt_q   <= '0;
      sig_q       <= '0;
      ver_q       <= '0;
      src_q       <= '0;
      tgt_q       <= '0;
      rec_len_q   <= '0;
      entries_q   <= '0;
      loc_cnt_q   <= '0;
      data_left_q <= '0;
      wptr_q      <= '0;
    end else begin
      phase_q     <= phase_d;
      err_q       <= err_d;
      hdr_cnt_q   <= hdr_cnt_d;
      sig_q       <= sig_d;
      ver_q       <= ver_d;
      src_q       <= src_d;
      tgt_q       <= tgt_d;
      rec_len_q   <= rec_len_d;
      entries_q   <= entries_d;
      loc_cnt_q   <= loc_cnt_d;
      data_left_q <= data_left_d;
      wptr_q      <= wptr_d;
    end
  end

  // Output register with a skid register behind it.
  logic              out_vld_q, out_vld_d;
  logic              skid_vld_q, skid_vld_d;
  rpsa_pkg::result_t out_q, out_d;
  rpsa_pkg::result_t skid_q, skid_d;

  assign patch_i.ready = !skid_vld_q;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (!out_vld_q || result_o.ready) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_vld_d = 1'b0;
      end else begin
        out_d     = res;
        out_vld_d = in_acc;
      end
    end else if (in_acc) begin
      skid_d     = res;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign result_o.valid         = out_vld_q;
  assign result_o.write_valid   = out_q.write_valid;
  assign result_o.write_address = out_q.write_address;
  assign result_o.write_data    = out_q.write_data;
  assign result_o.status        = out_q.status;
  assign result_o.target_hash   = out_q.target_hash;

  // The skid register is only filled while the output register holds a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_vld_q |-> out_vld_q)
    else $error("skid register holds a result while the output register is empty");

  // Errors stay until reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != rpsa_pkg::ST_BUSY) |=> (err_q == $past(err_q)))
    else $error("sticky error code changed");

  // A ROM write is produced only for a byte taken in the data phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && res.write_valid) |-> (phase_q == rpsa_pkg::PH_DATA))
    else $error("ROM write outside the data phase");

  // Done and an error never coexist.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == rpsa_pkg::PH_DONE) |-> (err_q == rpsa_pkg::ST_BUSY))
    else $error("done reached together with an error");

endmodule

`default_nettype wire

// ===== dv/tb_rom_patch_stream_applier.sv =====
// Self-checking testbench for the ROM patch stream applier, with its patch parser scoreboard.
`timescale 1ns / 1ps

// Mirrors the patch parser and checks every result request against its prediction.
class patch_checker;
  int unsigned rom_bytes;

  logic [63:0] want_signature;
  logic [7:0]  want_version;
  logic [63:0] want_source;

  rpsa_pkg::phase_e  ph;
  int unsigned       hdr_count;
  logic [63:0]       sig_acc;
  logic [7:0]        ver_acc;
  logic [63:0]       src_acc;
  logic [63:0]       tgt_acc;
  logic [7:0]        rec_len;
  logic [7:0]        entries;
  int unsigned       loc_count;
  logic [7:0]        data_left;
  logic [23:0]       ptr;
  rpsa_pkg::status_e err;

  rpsa_pkg::result_t due_results[$];
  int unsigned       bytes_taken;
  int unsigned       writes_due;
  int unsigned       results_checked;
  int unsigned       mismatches;
  logic [2:0]        last_status;

  function new(int unsigned rom_limit);
    rom_bytes       = rom_limit;
    want_signature  = '0;
    want_version    = 8'd1;
    want_source     = '0;
    ph              = rpsa_pkg::PH_HEADER;
    hdr_count       = 0;
    sig_acc         = '0;
    ver_acc         = '0;
    src_acc         = '0;
    tgt_acc         = '0;
    rec_len         = '0;
    entries         = '0;
    loc_count       = 0;
    data_left       = '0;
    ptr             = '0;
    err             = rpsa_pkg::ST_BUSY;
    bytes_taken     = 0;
    writes_due      = 0;
    results_checked = 0;
    mismatches      = 0;
    last_status     = rpsa_pkg::ST_BUSY;
  endfunction

  function void set_register(rpsa_pkg::cfg_reg_e idx, logic [63:0] value);
    case (idx)
      rpsa_pkg::CFG_SIGNATURE:   want_signature = value;
      rpsa_pkg::CFG_VERSION:     want_version = value[7:0];
      rpsa_pkg::CFG_SOURCE_HASH: want_source = value;
      default: ;
    endcase
  endfunction

  function int unsigned pending();
    return due_results.size();
  endfunction

  function void take_patch_byte(logic [7:0] b, logic eof);
    rpsa_pkg::result_t r;
    r = '0;
    bytes_taken++;
    if (err == rpsa_pkg::ST_BUSY && ph != rpsa_pkg::PH_DONE) begin
      case (ph)
        rpsa_pkg::PH_HEADER: begin
          if (hdr_count < 8) sig_acc = {b, sig_acc[63:8]};
          else if (hdr_count == 8) ver_acc = b;
          else if (hdr_count < 17) src_acc = {b, src_acc[63:8]};
          else tgt_acc = {b, tgt_acc[63:8]};
          hdr_count++;
          if (hdr_count >= rpsa_pkg::HeaderBytes) begin
            if (sig_acc != want_signature) err = rpsa_pkg::ST_INVALID;
            else if (ver_acc != want_version) err = rpsa_pkg::ST_VERSION;
            else if (src_acc != want_source) err = rpsa_pkg::ST_SOURCE;
            else ph = rpsa_pkg::PH_LENGTH;
          end
        end
        rpsa_pkg::PH_LENGTH: begin
          rec_len = b;
          ph = rpsa_pkg::PH_COUNT;
        end
        rpsa_pkg::PH_COUNT: begin
          entries = b;
          if (b == 8'd0) begin
            ph = rpsa_pkg::PH_LENGTH;
          end else begin
            loc_count = 0;
            ph = rpsa_pkg::PH_LOCATION;
          end
        end
        rpsa_pkg::PH_LOCATION: begin
          ptr = {b, ptr[23:8]};
          loc_count++;
          if (loc_count >= 3) begin
            loc_count = 0;
            if (rec_len == 8'd0 || 32'(ptr) + 32'(rec_len) > rom_bytes) begin
              err = rpsa_pkg::ST_INVALID;
            end else begin
              data_left = rec_len;
              ph = rpsa_pkg::PH_DATA;
            end
          end
        end
        rpsa_pkg::PH_DATA: begin
          if (data_left == 8'd0) begin
            err = rpsa_pkg::ST_INVALID;
          end else begin
            r.write_valid = 1'b1;
            r.write_address = ptr[rpsa_pkg::AddrWidth-1:0];
            r.write_data = b;
            writes_due++;
            ptr = ptr + 24'd1;
            data_left = data_left - 8'd1;
            if (data_left == 8'd0) begin
              entries = entries - 8'd1;
              ph = (entries == 8'd0) ? rpsa_pkg::PH_LENGTH : rpsa_pkg::PH_LOCATION;
            end
          end
        end
        default: err = rpsa_pkg::ST_INVALID;
      endcase
      if (eof && err == rpsa_pkg::ST_BUSY) begin
        if (ph == rpsa_pkg::PH_LENGTH) ph = rpsa_pkg::PH_DONE;
        else err = rpsa_pkg::ST_INVALID;
      end
    end
    if (err != rpsa_pkg::ST_BUSY) r.status = err;
    else if (ph == rpsa_pkg::PH_DONE) r.status = rpsa_pkg::ST_DONE;
    else r.status = rpsa_pkg::ST_BUSY;
    r.target_hash = (r.status == rpsa_pkg::ST_DONE) ? tgt_acc : 64'd0;
    due_results.push_back(r);
  endfunction

  function void compare_field(string field, logic [63:0] want_v, logic [63:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("MISMATCH result %0d %s: expected %h, got %h",
                 results_checked, field, want_v, got_v);
      end
    end
  endfunction

  function void check_rom_result(logic wv, logic [rpsa_pkg::AddrWidth-1:0] addr,
                                 logic [7:0] data, logic [2:0] st, logic [63:0] hash);
    rpsa_pkg::result_t want;
    results_checked++;
    last_status = st;
    if (due_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("MISMATCH result %0d arrived with no patch byte waiting", results_checked);
      end
      return;
    end
    want = due_results.pop_front();
    compare_field("write_valid", 64'(want.write_valid), 64'(wv));
    compare_field("write_address", 64'(want.write_address), 64'(addr));
    compare_field("write_data", 64'(want.write_data), 64'(data));
    compare_field("status", 64'(want.status), 64'(st));
    compare_field("target_hash", want.target_hash, hash);
  endfunction
endclass

module tb_rom_patch_stream_applier;

  localparam int unsigned RomBytes  = rpsa_pkg::RomBytesDefault;
  // Longest quiet stretch is the receiver hold-off plus a sender gap; this is
  // several times that.
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned HoldCycles = 300;

  // How the one patch file of this run ends; the seed picks it.
  typedef enum {
    END_CLEAN,
    END_TRUNCATED,
    END_ZERO_LENGTH,
    END_OUT_OF_RANGE,
    END_BAD_SIGNATURE,
    END_BAD_VERSION,
    END_BAD_SOURCE
  } file_ending_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [63:0] cfg_data_i;

  rpsa_in_if  patch_if ();
  rpsa_out_if result_if ();

  rom_patch_stream_applier #(
    .ROM_BYTES(RomBytes)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .patch_i    (patch_if),
    .result_o   (result_if)
  );

  patch_checker sb;

  // Bytes of the patch file waiting to be offered: {end_of_file, patch_byte}.
  logic [8:0]   stream_q[$];
  file_ending_e ending;

  // Sender burst state. A burst is a run of back-to-back requests; between
  // bursts valid drops for a random gap or stays high.
  int unsigned  burst_left = 0;
  bit           offering = 1'b0;

  // Receiver side bookkeeping.
  int unsigned  results_seen = 0;
  int unsigned  hold_left = 0;
  bit           hold_done = 1'b0;
  int unsigned  rx_cycle = 0;
  int unsigned  rx_mode = 0;

  int unsigned  idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Stream building. These only fill stream_q; flush_stream offers the bytes.
  // ---------------------------------------------------------------------------

  function automatic void push_byte(logic [7:0] b, logic eof);
    stream_q.push_back({eof, b});
  endfunction

  function automatic void push_word64(logic [63:0] w);
    for (int i = 0; i < 8; i++) push_byte(w[8*i +: 8], 1'b0);
  endfunction

  function automatic void push_loc(logic [23:0] loc);
    for (int i = 0; i < 3; i++) push_byte(loc[8*i +: 8], 1'b0);
  endfunction

  // Zero, all ones or a random word, so header and register extremes show up.
  function automatic logic [63:0] pick_word64();
    int unsigned r;
    r = $urandom_range(0, 3);
    if (r == 0) return 64'd0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [7:0] pick_data();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  // A start address that keeps the whole entry inside the ROM, with both
  // ends of the range favored.
  function automatic logic [23:0] pick_loc(int unsigned len);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 24'd0;
    if (r == 1) return 24'(RomBytes - len);
    return 24'($urandom_range(0, RomBytes - len));
  endfunction

  // One record; with eof_last the file ends on its final byte, which is the
  // count byte when the record has no entries.
  function automatic void push_record(int unsigned len, int unsigned cnt, bit eof_last);
    push_byte(8'(len), 1'b0);
    push_byte(8'(cnt), eof_last && cnt == 0);
    for (int e = 0; e < int'(cnt); e++) begin
      push_loc(pick_loc(len));
      for (int d = 0; d < int'(len); d++) begin
        push_byte(pick_data(), eof_last && e == int'(cnt) - 1 && d == int'(len) - 1);
      end
    end
  endfunction

  // Mostly short entries; now and then long ones, empty records and records
  // whose length byte is never used.
  function automatic void push_random_record();
    int unsigned r;
    int unsigned len;
    int unsigned cnt;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      len = $urandom_range(1, 8);
      cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
    end else if (r < 85) begin
      len = $urandom_range(9, 40);
      cnt = $urandom_range(1, 2);
    end else if (r < 92) begin
      len = ($urandom_range(0, 1) == 0) ? 255 : $urandom_range(128, 254);
      cnt = 1;
    end else if (r < 97) begin
      len = $urandom_range(0, 255);
      cnt = 0;
    end else begin
      len = 0;
      cnt = 0;
    end
    push_record(len, cnt, 1'b0);
  endfunction

  function automatic void push_random_records(int unsigned target);
    int unsigned start;
    start = stream_q.size();
    while (stream_q.size() - start < target) push_random_record();
  endfunction

  // Bytes after the file has finished or failed; the block must ignore them.
  function automatic void push_noise(int unsigned n);
    for (int i = 0; i < int'(n); i++) push_byte(8'($urandom), 1'($urandom));
  endfunction

  function automatic file_ending_e pick_ending();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 6) return END_CLEAN;
    if (r < 9) return END_TRUNCATED;
    if (r < 11) return END_ZERO_LENGTH;
    if (r < 13) return END_OUT_OF_RANGE;
    if (r == 13) return END_BAD_SIGNATURE;
    if (r == 14) return END_BAD_VERSION;
    return END_BAD_SOURCE;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving tasks.
  // ---------------------------------------------------------------------------

  // Offers one patch byte and returns once it is accepted and any gap after its
  // burst is over. valid stays high into the next request unless a gap follows
  // the burst, so a continuing valid is never lowered and raised in the same step.
  task automatic send_byte(input logic [7:0] b, input logic eof);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 40);
    end
    patch_if.valid       <= 1'b1;
    patch_if.patch_byte  <= b;
    patch_if.end_of_file <= eof;
    offering = 1'b1;
    do @(posedge clk_i); while (!(patch_if.valid && patch_if.ready));
    sb.take_patch_byte(b, eof);
    burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        patch_if.valid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic flush_stream();
    logic [8:0] item;
    while (stream_q.size() != 0) begin
      item = stream_q.pop_front();
      send_byte(item[7:0], item[8]);
    end
  endtask

  // Stops offering and waits until every predicted result has come back, then
  // lets the clock run on so that the block is surely idle.
  task automatic drain_results();
    if (offering) begin
      patch_if.valid <= 1'b0;
      offering = 1'b0;
    end
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Writes all three registers on consecutive edges. The version write
  // carries random upper bits that the block has to drop.
  task automatic write_settings(input logic [63:0] sig, input logic [7:0] ver,
                                input logic [63:0] src);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= rpsa_pkg::CFG_SIGNATURE;
    cfg_data_i  <= sig;
    @(posedge clk_i);
    sb.set_register(rpsa_pkg::CFG_SIGNATURE, sig);
    cfg_index_i <= rpsa_pkg::CFG_VERSION;
    cfg_data_i  <= {$urandom, 24'($urandom), ver};
    @(posedge clk_i);
    sb.set_register(rpsa_pkg::CFG_VERSION, {56'd0, ver});
    cfg_index_i <= rpsa_pkg::CFG_SOURCE_HASH;
    cfg_data_i  <= src;
    @(posedge clk_i);
    sb.set_register(rpsa_pkg::CFG_SOURCE_HASH, src);
    cfg_we_i    <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: checks each accepted result request and drives ready. The stall
  // pattern is picked anew at regular intervals from always ready, mostly ready,
  // mostly stalled and one cycle in four. Once, after 100 results, ready stays
  // low for a long stretch so the skid stage fills and the input backs up.
  // ---------------------------------------------------------------------------
  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (result_if.valid && result_if.ready) begin
        sb.check_rom_result(result_if.write_valid, result_if.write_address,
                            result_if.write_data, result_if.status, result_if.target_hash);
        results_seen++;
      end
      if (!hold_done && results_seen >= 100) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      rx_cycle++;
      if (rx_cycle % 50 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left != 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: result_if.ready <= 1'b1;
          1: result_if.ready <= ($urandom_range(0, 3) != 0);
          2: result_if.ready <= ($urandom_range(0, 3) == 0);
          default: result_if.ready <= (rx_cycle % 4 == 0);
        endcase
      end
    end
  end

  // Watchdog: a run where no request moves on either side for too long has
  // hung.
  always @(posedge clk_i) begin
    if ((patch_if.valid && patch_if.ready) || (result_if.valid && result_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no request accepted for %0d cycles", IdleLimit);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence. Errors and done are sticky and reset comes only once, so
  // the run is a single patch file: a header, a directed part, a long random
  // part in two halves, and then one ending picked by the seed. Registers are
  // rewritten between parts while the block is idle; after the header they no
  // longer change behavior, but the checker still mirrors them.
  // ---------------------------------------------------------------------------
  initial begin
    logic [63:0]  sig;
    logic [7:0]   ver;
    logic [63:0]  src;
    logic [63:0]  tgt;
    int unsigned  start;
    int unsigned  len;

    sb = new(RomBytes);
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_index_i          <= rpsa_pkg::CFG_SIGNATURE;
    cfg_data_i           <= 64'd0;
    patch_if.valid       <= 1'b0;
    patch_if.patch_byte  <= 8'd0;
    patch_if.end_of_file <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    ending = pick_ending();
    sig = pick_word64();
    src = pick_word64();
    tgt = pick_word64();
    case ($urandom_range(0, 3))
      0: ver = 8'h00;
      1: ver = 8'hFF;
      default: ver = 8'($urandom);
    endcase
    write_settings(sig, ver, src);

    // Header, corrupted to match a bad-header ending. A bad signature may come
    // with a bad version too, and a bad version with a bad source hash, so the
    // order of the checks is exercised.
    case (ending)
      END_BAD_SIGNATURE: begin
        sig = sig ^ (64'd1 << $urandom_range(0, 63));
        if ($urandom_range(0, 1) == 0) ver = ver ^ 8'(1 << $urandom_range(0, 7));
        if ($urandom_range(0, 1) == 0) src = ~src;
      end
      END_BAD_VERSION: begin
        ver = ver ^ 8'(1 << $urandom_range(0, 7));
        if ($urandom_range(0, 1) == 0) src = src ^ (64'd1 << $urandom_range(0, 63));
      end
      END_BAD_SOURCE: begin
        src = src ^ (64'd1 << $urandom_range(0, 63));
      end
      default: ;
    endcase
    push_word64(sig);
    push_byte(ver, 1'b0);
    push_word64(src);
    push_word64(tgt);

    // Directed records: an empty record with length zero, an empty record with
    // the largest length, a one-byte write at address zero, a two-byte write
    // ending on the last ROM byte, and a two-entry record that steps from one
    // entry's data straight into the next location.
    push_byte(8'd0, 1'b0);
    push_byte(8'd0, 1'b0);
    push_byte(8'd255, 1'b0);
    push_byte(8'd0, 1'b0);
    push_byte(8'd1, 1'b0);
    push_byte(8'd1, 1'b0);
    push_loc(24'd0);
    push_byte(8'h00, 1'b0);
    push_byte(8'd2, 1'b0);
    push_byte(8'd1, 1'b0);
    push_loc(24'(RomBytes - 2));
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'd1, 1'b0);
    push_byte(8'd2, 1'b0);
    push_loc(24'd1);
    push_byte(8'h5A, 1'b0);
    push_loc(24'(RomBytes - 1));
    push_byte(8'hA5, 1'b0);
    flush_stream();
    drain_results();
    write_settings('1, 8'h00, 64'd0);

    // Random records. When the header failed, the block ignores all of these
    // and only repeats its error status, which is checked all the same.
    push_random_records(900);
    flush_stream();
    drain_results();
    write_settings(64'd0, 8'hFF, '1);
    push_random_records(900);

    case (ending)
      END_CLEAN: begin
        // End on the last data byte or on the count byte of an empty record.
        if ($urandom_range(0, 1) == 0) push_record($urandom_range(1, 8), $urandom_range(1, 3), 1'b1);
        else push_record($urandom_range(0, 255), 0, 1'b1);
      end
      END_TRUNCATED: begin
        // End of file on any byte of a one-entry record but its last one.
        start = stream_q.size();
        push_record($urandom_range(1, 6), 1, 1'b0);
        stream_q[$urandom_range(start, stream_q.size() - 2)][8] = 1'b1;
      end
      END_ZERO_LENGTH: begin
        push_byte(8'd0, 1'b0);
        push_byte(8'($urandom_range(1, 255)), 1'b0);
        push_loc(24'($urandom));
      end
      END_OUT_OF_RANGE: begin
        // Entry that runs past the ROM end, often by exactly one byte. Its data
        // bytes follow and must not be written.
        len = $urandom_range(1, 255);
        push_byte(8'(len), 1'b0);
        push_byte(8'd1, 1'b0);
        if ($urandom_range(0, 1) == 0) push_loc(24'(RomBytes - len + 1));
        else push_loc(24'($urandom_range(RomBytes - len + 1, 24'hFFFFFF)));
        for (int d = 0; d < int'(len); d++) push_byte(pick_data(), 1'b0);
      end
      default: ;
    endcase
    push_noise(20);
    flush_stream();
    drain_results();
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d patch bytes and %0d ROM writes; file ending %s.",
             sb.bytes_taken, sb.writes_due, ending.name());
    $display("Results checked: %0d, final status %0d, mismatches: %0d.",
             sb.results_checked, sb.last_status, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
